// ----- src/tpdc_pkg.sv -----
// tpdc_pkg: shared types and constants of the time-of-flight depth colorizer.
// Used by tpdc_div and tof_pixel_depth_colorize_top; depends on nothing.
package tpdc_pkg;

	localparam int PHASE_W = 16;
	localparam int AMP_W   = 16;
	localparam int DIST_W  = 15;
	localparam int COLOR_W = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// sensor status codes carried in the phase word
	localparam logic [PHASE_W-1:0] PHASE_OVERFLOW  = 16'd65500;
	localparam logic [PHASE_W-1:0] PHASE_SATURATED = 16'd65400;

	// 12500/30000 = 5/12: (5*ph >> 2) / 3, the /3 by reciprocal 43691 / 2^17.
	// Exact for any dividend below 2^17.
	localparam logic [15:0] RECIP_3     = 16'd43691;
	localparam int          RECIP_SHIFT = 17;

	localparam logic [COLOR_W-1:0] FULL_COLOR = 8'd255;

	// divider geometry: 8 quotient bits, 2 per stage
	localparam int QUO_BITS       = COLOR_W;
	localparam int BITS_PER_STAGE = 2;
	localparam int DIV_STAGES     = QUO_BITS / BITS_PER_STAGE;
	localparam int REM_W          = DIST_W + COLOR_W;

	// register reset values
	localparam logic [15:0]       AMP_THR_RST   = 16'd20;
	localparam logic [15:0]       PHASE_THR_RST = 16'd200;
	localparam logic [DIST_W-1:0] OFFSET_RST    = 15'd0;
	localparam logic [DIST_W-1:0] COLOR_MIN_RST = 15'd0;
	localparam logic [DIST_W-1:0] COLOR_MAX_RST = 15'd15000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AMP_THR   = 3'd0,
		REG_PHASE_THR = 3'd1,
		REG_OFFSET    = 3'd2,
		REG_COLOR_MIN = 3'd3,
		REG_COLOR_MAX = 3'd4
	} cfg_reg_t;

	// which channel takes the divider quotient
	typedef enum logic [1:0] {
		SEL_NONE,
		SEL_RED,
		SEL_GREEN,
		SEL_BLUE
	} chan_sel_t;

	typedef enum logic [1:0] {
		CLS_BLACK,
		CLS_RED,
		CLS_MAGENTA,
		CLS_SCALE
	} color_cls_t;

	// pixel data riding alongside the divider
	typedef struct packed {
		logic [DIST_W-1:0]  dist_mm;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		chan_sel_t          sel;
	} pix_t;

endpackage

// ----- src/tpdc_div.sv -----
// tpdc_div: pipelined restoring divider, floor(255*num/span) for num <= span,
// two quotient bits per stage, carrying pixel data alongside. Uses tpdc_pkg.
module tpdc_div import tpdc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [DIST_W-1:0]  num,
	input  logic [DIST_W-1:0]  span,
	input  pix_t               pix,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [QUO_BITS-1:0] quo,
	output pix_t               out_pix
);

	logic                vld_s  [DIV_STAGES];
	logic [REM_W-1:0]    rem_s  [DIV_STAGES];
	logic [QUO_BITS-1:0] quo_s  [DIV_STAGES];
	logic [DIST_W-1:0]   span_s [DIV_STAGES];
	pix_t                pix_s  [DIV_STAGES];
	logic [DIV_STAGES:0] rdy;

	assign rdy[DIV_STAGES] = !out_stall;
	assign in_stall        = !rdy[0];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		localparam int HI = QUO_BITS - 1 - BITS_PER_STAGE * k;

		logic                v_in;
		logic [REM_W-1:0]    rem_in;
		logic [QUO_BITS-1:0] quo_in;
		logic [DIST_W-1:0]   span_in;
		pix_t                pix_in;
		logic [REM_W-1:0]    rem_out;
		logic [QUO_BITS-1:0] quo_out;
		logic [REM_W-1:0]    dsh;

		if (k == 0) begin : g_first
			// 255*num = 256*num - num
			assign rem_in  = {num, 8'd0} - REM_W'(num);
			assign quo_in  = '0;
			assign v_in    = in_valid;
			assign span_in = span;
			assign pix_in  = pix;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign quo_in  = quo_s[k-1];
			assign v_in    = vld_s[k-1];
			assign span_in = span_s[k-1];
			assign pix_in  = pix_s[k-1];
		end

		always_comb begin
			rem_out = rem_in;
			quo_out = quo_in;
			dsh     = '0;
			for (int j = 0; j < BITS_PER_STAGE; j++) begin
				dsh = REM_W'(span_in) << (HI - j);
				if (rem_out >= dsh) begin
					rem_out         = rem_out - dsh;
					quo_out[HI - j] = 1'b1;
				end
			end
		end

		assign rdy[k] = !vld_s[k] || rdy[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && v_in) begin
				rem_s[k]  <= rem_out;
				quo_s[k]  <= quo_out;
				span_s[k] <= span_in;
				pix_s[k]  <= pix_in;
			end
		end
	end

	assign out_valid = vld_s[DIV_STAGES-1];
	assign quo       = quo_s[DIV_STAGES-1];
	assign out_pix   = pix_s[DIV_STAGES-1];

endmodule

// ----- src/tof_pixel_depth_colorize_top.sv -----
// tof_pixel_depth_colorize_top: phase/amplitude to distance and rainbow color.
// Uses tpdc_pkg and tpdc_div.
//
// Usage:
//  - Pixel channel (pixel_valid / pixel_stall, phase, amplitude): one beat per
//    pixel. Depth channel (depth_valid / depth_stall, distance_mm, red, green,
//    blue): one beat per pixel, in input order.
//  - Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data): cfg_ready is
//    always high. Index 0 amplitude threshold, 1 phase threshold, 2 distance
//    offset, 3 color minimum, 4 color maximum; other indexes are dropped.
//    Write only while no pixel is in flight.
//  - Pipeline: pixel beat to depth_valid passes 5 front stages (checks,
//    reciprocal multiply, offset, scale range, segment select), then 4
//    divider stages of two quotient bits each, then the output register.
//  - Throughput: one pixel per cycle while depth_stall stays low; the 17x16
//    reciprocal multiply fits one stage and the divider retires two quotient
//    bits per stage, so nothing iterates.
//  - Stall: each stage holds only if it is full and the stage after it holds,
//    so empty slots fill while the output waits; pixel_stall rises once the
//    whole pipeline is full behind a stalled depth beat. Nothing is dropped.
//  - Reset: all stages empty, registers return to 20 / 200 / 0 / 0 / 15000.
module tof_pixel_depth_colorize_top import tpdc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// pixel input
	input  logic                  pixel_valid,
	output logic                  pixel_stall,
	input  logic [PHASE_W-1:0]    phase,
	input  logic [AMP_W-1:0]      amplitude,
	// depth/color output
	output logic                  depth_valid,
	input  logic                  depth_stall,
	output logic [DIST_W-1:0]     distance_mm,
	output logic [COLOR_W-1:0]    red,
	output logic [COLOR_W-1:0]    green,
	output logic [COLOR_W-1:0]    blue,
	// register writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// ---------------- configuration registers ----------------
	logic [AMP_W-1:0]   amp_thr_q;
	logic [PHASE_W-1:0] phase_thr_q;
	logic [DIST_W-1:0]  offset_q;
	logic [DIST_W-1:0]  color_min_q;
	logic [DIST_W-1:0]  color_max_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_thr_q   <= AMP_THR_RST;
			phase_thr_q <= PHASE_THR_RST;
			offset_q    <= OFFSET_RST;
			color_min_q <= COLOR_MIN_RST;
			color_max_q <= COLOR_MAX_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_AMP_THR:   amp_thr_q   <= cfg_data;
				REG_PHASE_THR: phase_thr_q <= cfg_data;
				REG_OFFSET:    offset_q    <= cfg_data[DIST_W-1:0];
				REG_COLOR_MIN: color_min_q <= cfg_data[DIST_W-1:0];
				REG_COLOR_MAX: color_max_q <= cfg_data[DIST_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- flow control ----------------
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s10;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s10;
	logic div_in_stall, div_out_valid;

	assign rdy_s10 = !vld_s10 || !depth_stall;
	assign rdy_s5  = !vld_s5 || !div_in_stall;
	assign rdy_s4  = !vld_s4 || rdy_s5;
	assign rdy_s3  = !vld_s3 || rdy_s4;
	assign rdy_s2  = !vld_s2 || rdy_s3;
	assign rdy_s1  = !vld_s1 || rdy_s2;
	assign pixel_stall = !rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s10 <= 1'b0;
		end else begin
			if (rdy_s1)  vld_s1  <= pixel_valid;
			if (rdy_s2)  vld_s2  <= vld_s1;
			if (rdy_s3)  vld_s3  <= vld_s2;
			if (rdy_s4)  vld_s4  <= vld_s3;
			if (rdy_s5)  vld_s5  <= vld_s4;
			if (rdy_s10) vld_s10 <= div_out_valid;
		end
	end

	// ---------------- stage 1: validity checks, 5*phase/4 ----------------
	logic                         inv_s1;
	logic [PHASE_W:0]             y_s1;   // floor(5*phase/4), 17 bits
	logic [PHASE_W+2:0]           ph5;

	assign ph5 = {phase, 2'b00} + (PHASE_W+3)'(phase);

	always_ff @(posedge clk) begin
		if (rdy_s1 && pixel_valid) begin
			inv_s1 <= (phase == PHASE_OVERFLOW) || (phase == PHASE_SATURATED) ||
			          (phase < phase_thr_q) || (amplitude < amp_thr_q);
			y_s1   <= ph5[PHASE_W+2:2];
		end
	end

	// ---------------- stage 2: divide by 3 via reciprocal ----------------
	logic [31:0]       prod;
	logic              inv_s2;
	logic [DIST_W-1:0] draw_s2;

	assign prod = 32'(y_s1) * 32'(RECIP_3);

	always_ff @(posedge clk) begin
		if (rdy_s2 && vld_s1) begin
			inv_s2  <= inv_s1;
			draw_s2 <= prod[RECIP_SHIFT +: DIST_W];
		end
	end

	// ---------------- stage 3: invalid mask, offset with clamp ----------------
	logic [DIST_W-1:0] dist_s3;

	always_ff @(posedge clk) begin
		if (rdy_s3 && vld_s2) begin
			if (inv_s2 || (draw_s2 <= offset_q))
				dist_s3 <= '0;
			else
				dist_s3 <= draw_s2 - offset_q;
		end
	end

	// ---------------- stage 4: position on the color scale ----------------
	color_cls_t        cls_nx;
	color_cls_t        cls_s4;
	logic [DIST_W-1:0] dist_s4, e_s4, span_s4;

	always_comb begin
		if (dist_s3 == '0)
			cls_nx = CLS_BLACK;
		else if (dist_s3 < color_min_q)
			cls_nx = CLS_RED;
		else if (dist_s3 > color_max_q)
			cls_nx = CLS_MAGENTA;
		else if (color_max_q == color_min_q)
			cls_nx = CLS_BLACK;    // zero span
		else
			cls_nx = CLS_SCALE;
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && vld_s3) begin
			cls_s4  <= cls_nx;
			dist_s4 <= dist_s3;
			e_s4    <= dist_s3 - color_min_q;
			span_s4 <= color_max_q - color_min_q;
		end
	end

	// ---------------- stage 5: segment select ----------------
	logic [DIST_W+2:0] e5, sp1, sp2, sp3, sp4;
	pix_t              pix_nx;
	logic [DIST_W-1:0] num_nx;
	pix_t              pix_s5;
	logic [DIST_W-1:0] num_s5, span_s5;

	assign e5  = {e_s4, 2'b00} + (DIST_W+3)'(e_s4);
	assign sp1 = (DIST_W+3)'(span_s4);
	assign sp2 = (DIST_W+3)'({span_s4, 1'b0});
	assign sp3 = sp2 + sp1;
	assign sp4 = {1'b0, span_s4, 2'b00};

	always_comb begin
		pix_nx.dist_mm = dist_s4;
		pix_nx.red     = '0;
		pix_nx.green   = '0;
		pix_nx.blue    = '0;
		pix_nx.sel     = SEL_NONE;
		num_nx         = '0;
		case (cls_s4)
			CLS_RED: begin
				pix_nx.red = FULL_COLOR;
			end
			CLS_MAGENTA: begin
				pix_nx.red  = FULL_COLOR;
				pix_nx.blue = FULL_COLOR;
			end
			CLS_SCALE: begin
				if (e5 > sp4) begin
					pix_nx.blue = FULL_COLOR;
					pix_nx.sel  = SEL_RED;
					num_nx      = DIST_W'(e5 - sp4);
				end else if (e5 > sp3) begin
					pix_nx.blue = FULL_COLOR;
					pix_nx.sel  = SEL_GREEN;
					num_nx      = DIST_W'(sp4 - e5);
				end else if (e5 > sp2) begin
					pix_nx.green = FULL_COLOR;
					pix_nx.sel   = SEL_BLUE;
					num_nx       = DIST_W'(e5 - sp2);
				end else if (e5 > sp1) begin
					pix_nx.green = FULL_COLOR;
					pix_nx.sel   = SEL_RED;
					num_nx       = DIST_W'(sp2 - e5);
				end else begin
					pix_nx.red = FULL_COLOR;
					pix_nx.sel = SEL_GREEN;
					num_nx     = DIST_W'(e5);
				end
			end
			default: ;    // black
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy_s5 && vld_s4) begin
			pix_s5  <= pix_nx;
			num_s5  <= num_nx;
			span_s5 <= span_s4;
		end
	end

	// ---------------- stages 6-9: 255*num/span ----------------
	logic [QUO_BITS-1:0] div_quo;
	pix_t                div_pix;

	tpdc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s5),
		.in_stall  (div_in_stall),
		.num       (num_s5),
		.span      (span_s5),
		.pix       (pix_s5),
		.out_valid (div_out_valid),
		.out_stall (!rdy_s10),
		.quo       (div_quo),
		.out_pix   (div_pix)
	);

	// ---------------- stage 10: output register ----------------
	logic [DIST_W-1:0]  dist_s10;
	logic [COLOR_W-1:0] red_s10, green_s10, blue_s10;

	always_ff @(posedge clk) begin
		if (rdy_s10 && div_out_valid) begin
			dist_s10  <= div_pix.dist_mm;
			red_s10   <= (div_pix.sel == SEL_RED)   ? div_quo : div_pix.red;
			green_s10 <= (div_pix.sel == SEL_GREEN) ? div_quo : div_pix.green;
			blue_s10  <= (div_pix.sel == SEL_BLUE)  ? div_quo : div_pix.blue;
		end
	end

	assign depth_valid = vld_s10;
	assign distance_mm = dist_s10;
	assign red         = red_s10;
	assign green       = green_s10;
	assign blue        = blue_s10;

`ifndef NO_ASSERTIONS
	// an invalid or zero distance is always black
	a_zero_black: assert property (@(posedge clk) disable iff (!arst_n)
		depth_valid && (distance_mm == '0) |-> (red == '0) && (green == '0) && (blue == '0))
		else $error("zero distance not black");

	// the rainbow never lights all three channels
	a_two_channels: assert property (@(posedge clk) disable iff (!arst_n)
		depth_valid |-> !((red != '0) && (green != '0) && (blue != '0)))
		else $error("all three color channels nonzero");

	// input backpressure only with a full first stage behind a full pipe
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_stall |-> vld_s1 && vld_s5 && depth_valid && depth_stall)
		else $error("pixel_stall with an empty slot in the pipeline");
`endif

endmodule

// ----- dv/tof_pixel_depth_colorize_top_test.sv -----
`timescale 1ns / 100ps
// Testbench for the time-of-flight depth colorizer: directed and random pixels against a scoreboard
// whose own depth/rainbow predictor runs on a mirror of the register file.
// Depends on tpdc_pkg and tof_pixel_depth_colorize_top.
module tof_pixel_depth_colorize_top_test;
	import tpdc_pkg::*;

	localparam int PIPE_LATENCY = 10;      // pixel beat to depth_valid
	localparam int CYCLE_LIMIT  = 400000;
	localparam int IDLE_PCT     = 27;
	localparam int MAX_SHOWN    = 10;
	localparam int PHASE_TOP    = (1 << PHASE_W) - 1;
	localparam int AMP_TOP      = (1 << AMP_W) - 1;
	localparam int SEGMENTS     = 5;
	localparam int unsigned RANGE_MM   = 12500;
	localparam int unsigned PHASE_FULL = 30000;
	localparam int unsigned COLOR_TOP  = 255;
	// indexes past the last register: writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [DIST_W-1:0]  dist_mm;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} depth_beat_t;

	// Mirror of the register file plus the queue of depth beats still owed by the block.
	class depth_scoreboard;
		logic [AMP_W-1:0]   amp_thr;
		logic [PHASE_W-1:0] phase_thr;
		logic [DIST_W-1:0]  offset;
		logic [DIST_W-1:0]  color_min;
		logic [DIST_W-1:0]  color_max;
		depth_beat_t        owed_q[$];
		int                 mismatches;

		function new();
			amp_thr    = AMP_THR_RST;
			phase_thr  = PHASE_THR_RST;
			offset     = OFFSET_RST;
			color_min  = COLOR_MIN_RST;
			color_max  = COLOR_MAX_RST;
			mismatches = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_AMP_THR: begin
					amp_thr = data;
				end
				REG_PHASE_THR: begin
					phase_thr = data;
				end
				REG_OFFSET: begin
					offset = data[DIST_W-1:0];
				end
				REG_COLOR_MIN: begin
					color_min = data[DIST_W-1:0];
				end
				REG_COLOR_MAX: begin
					color_max = data[DIST_W-1:0];
				end
				default: begin
				end
			endcase
		endfunction

		// distance, then the five-segment rainbow in exact integer steps
		function depth_beat_t colorize_pixel(logic [PHASE_W-1:0] ph, logic [AMP_W-1:0] amp);
			depth_beat_t beat;
			int unsigned d, s, e5, r, g, b;
			d = 0;
			if (ph != PHASE_OVERFLOW && ph != PHASE_SATURATED && ph >= phase_thr && amp >= amp_thr) begin
				d = (RANGE_MM * ph) / PHASE_FULL;
				d = (d > offset) ? d - offset : 0;
			end
			r = 0;
			g = 0;
			b = 0;
			if (d == 0) begin
			end else if (d < color_min) begin
				r = COLOR_TOP;
			end else if (d > color_max) begin
				r = COLOR_TOP;
				b = COLOR_TOP;
			end else begin
				s = color_max - color_min;
				e5 = SEGMENTS * (d - color_min);
				if (s == 0) begin
					// zero span stays black
				end else if (e5 > 4 * s) begin
					r = (COLOR_TOP * (e5 - 4 * s)) / s;
					b = COLOR_TOP;
				end else if (e5 > 3 * s) begin
					g = (COLOR_TOP * (4 * s - e5)) / s;
					b = COLOR_TOP;
				end else if (e5 > 2 * s) begin
					g = COLOR_TOP;
					b = (COLOR_TOP * (e5 - 2 * s)) / s;
				end else if (e5 > s) begin
					r = (COLOR_TOP * (2 * s - e5)) / s;
					g = COLOR_TOP;
				end else begin
					r = COLOR_TOP;
					g = (COLOR_TOP * e5) / s;
				end
			end
			beat.dist_mm = d[DIST_W-1:0];
			beat.red     = r[COLOR_W-1:0];
			beat.green   = g[COLOR_W-1:0];
			beat.blue    = b[COLOR_W-1:0];
			return beat;
		endfunction

		function void note_pixel(logic [PHASE_W-1:0] ph, logic [AMP_W-1:0] amp);
			owed_q = {owed_q, colorize_pixel(ph, amp)};
		endfunction

		function void check_depth(depth_beat_t got);
			depth_beat_t want;
			if (owed_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("depth beat with no pixel owed: dist %0d rgb %0d %0d %0d",
						got.dist_mm, got.red, got.green, got.blue);
				return;
			end
			want = owed_q.pop_front();
			if (got.dist_mm !== want.dist_mm || got.red !== want.red ||
					got.green !== want.green || got.blue !== want.blue) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("depth mismatch: dist %0d/%0d red %0d/%0d green %0d/%0d blue %0d/%0d (exp/got)",
						want.dist_mm, got.dist_mm, want.red, got.red,
						want.green, got.green, want.blue, got.blue);
			end
		endfunction

		function int pending();
			return owed_q.size();
		endfunction
	endclass

	// every block input starts at a known value
	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  pixel_valid = 1'b0;
	logic                  pixel_stall;
	logic [PHASE_W-1:0]    phase = '0;
	logic [AMP_W-1:0]      amplitude = '0;
	logic                  depth_valid;
	logic                  depth_stall = 1'b0;
	logic [DIST_W-1:0]     distance_mm;
	logic [COLOR_W-1:0]    red;
	logic [COLOR_W-1:0]    green;
	logic [COLOR_W-1:0]    blue;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic quiet = 1'b0;  // no idling on either side while set
	int   cycles = 0;

	depth_scoreboard sb = new();

	tof_pixel_depth_colorize_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.phase       (phase),
		.amplitude   (amplitude),
		.depth_valid (depth_valid),
		.depth_stall (depth_stall),
		.distance_mm (distance_mm),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Output side backpressure: random stall, except in the quiet stretch.
	always @(posedge clk) begin
		depth_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
	end

	// Watchdog. A healthy run ends far below the limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Monitor. Everything is sampled at the edge that completes the handshake,
	// so register writes, accepted pixels and depth beats are seen in edge order.
	always @(posedge clk) begin : monitor
		depth_beat_t got;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
			if (pixel_valid && !pixel_stall)
				sb.note_pixel(phase, amplitude);
			if (depth_valid && !depth_stall) begin
				got.dist_mm = distance_mm;
				got.red     = red;
				got.green   = green;
				got.blue    = blue;
				sb.check_depth(got);
			end
		end
	end

	function automatic int clamp_word(int v);
		if (v < 0)
			return 0;
		if (v > PHASE_TOP)
			return PHASE_TOP;
		return v;
	endfunction

	// One pixel beat, with an occasional bubble ahead of it. Valid stays high
	// across back-to-back beats; callers drop it through settle().
	task automatic send_pixel(input int ph, input int amp);
		if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
			pixel_valid <= 1'b0;
			@(posedge clk);
		end
		pixel_valid <= 1'b1;
		phase       <= ph[PHASE_W-1:0];
		amplitude   <= amp[AMP_W-1:0];
		@(posedge clk);
		while (pixel_stall)
			@(posedge clk);
	endtask

	// Drain: every owed beat back, then the pipeline left to run empty.
	task automatic settle();
		pixel_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 2)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	// Full register load while idle. A spare-index write goes last, so an
	// aliasing decode would corrupt a live register and show up in the checks.
	task automatic program_regs(input logic [15:0] amp_thr, input logic [15:0] phase_thr,
			input logic [15:0] offset, input logic [15:0] cmin, input logic [15:0] cmax);
		settle();
		write_reg(REG_AMP_THR, amp_thr);
		write_reg(REG_PHASE_THR, phase_thr);
		write_reg(REG_OFFSET, offset);
		write_reg(REG_COLOR_MIN, cmin);
		write_reg(REG_COLOR_MAX, cmax);
		write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
			CFG_DATA_W'($urandom_range(0, AMP_TOP)));
		cfg_valid <= 1'b0;
	endtask

	// Random pixels aimed at the interesting spots of the current settings:
	// status codes, both thresholds, the color scale and its segment edges.
	task automatic run_random(input int count);
		int kind, ph, amp, lo, hi, target, span;
		for (int i = 0; i < count; i++) begin
			kind = $urandom_range(0, 99);
			ph   = $urandom_range(0, PHASE_TOP);
			if ($urandom_range(0, 99) < 85)
				amp = $urandom_range(int'(sb.amp_thr), AMP_TOP);
			else
				amp = $urandom_range(0, AMP_TOP);
			if (kind < 8) begin
				ph = ($urandom_range(0, 1) ? int'(PHASE_OVERFLOW) : int'(PHASE_SATURATED))
					+ int'($urandom_range(0, 2)) - 1;
			end else if (kind < 20) begin
				ph = clamp_word(int'(sb.phase_thr) + int'($urandom_range(0, 4)) - 2);
			end else if (kind < 30) begin
				amp = clamp_word(int'(sb.amp_thr) + int'($urandom_range(0, 4)) - 2);
			end else if (kind < 70) begin
				span = int'(sb.color_max) - int'(sb.color_min);
				if (kind < 45 && span > 0) begin
					// segment edges, endpoints included
					target = int'(sb.color_min) + (int'($urandom_range(0, SEGMENTS)) * span) / SEGMENTS
						+ int'($urandom_range(0, 2)) - 1;
				end else begin
					lo = int'(sb.color_min) - 2;
					hi = int'(sb.color_max) + 2;
					if (lo < 0)
						lo = 0;
					target = $urandom_range(lo, hi);
				end
				if (target < 0)
					target = 0;
				// smallest phase whose distance lands on target, plus a nudge that keeps it there
				ph = clamp_word(((target + int'(sb.offset)) * int'(PHASE_FULL) + int'(RANGE_MM) - 1)
					/ int'(RANGE_MM) + int'($urandom_range(0, 1)));
			end
			send_pixel(ph, amp);
		end
	endtask

	initial begin
		// reset held, then released on an edge
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset settings: invalid pixels, status codes, scale edges.
		send_pixel(0, 0);
		send_pixel(int'(PHASE_OVERFLOW), AMP_TOP);
		send_pixel(int'(PHASE_SATURATED), AMP_TOP);
		send_pixel(PHASE_OVERFLOW + 1, AMP_TOP);    // just past a code: far, magenta
		send_pixel(PHASE_TOP, AMP_TOP);             // longest distance
		send_pixel(PHASE_THR_RST - 1, 100);         // phase under threshold
		send_pixel(int'(PHASE_THR_RST), AMP_THR_RST - 1); // amplitude under threshold
		send_pixel(int'(PHASE_THR_RST), int'(AMP_THR_RST)); // both exactly at threshold
		send_pixel(7200, 500);                      // segment edges at 3000/6000/9000/12000 mm
		send_pixel(7203, 500);
		send_pixel(14400, 500);
		send_pixel(21600, 500);
		send_pixel(28800, 500);
		send_pixel(28803, 500);
		send_pixel(36000, 500);                     // exactly at the top of the scale
		send_pixel(36003, 500);                     // one past it

		// zero span: min == max == d is black, either side red / magenta
		program_regs(20, 200, 0, 5000, 5000);
		send_pixel(12000, 500);
		send_pixel(11998, 500);
		send_pixel(12003, 500);

		// inverted scale, thresholds off
		program_regs(0, 0, 0, 20000, 100);
		send_pixel(240, 500);
		send_pixel(60000, 500);
		send_pixel(1, 0);

		// offset with bit 15 set: masked to the largest offset, everything clamps to zero
		program_regs(0, 0, 16'hFFFF, 0, 100);
		send_pixel(PHASE_TOP, AMP_TOP);

		// Random phases over a spread of settings, extremes first.
		program_regs(0, 0, 0, 0, 32767);
		run_random(160);
		program_regs(16'hFFFF, 16'hFFFF, 0, 0, 32767);
		run_random(150);
		program_regs(20, 200, 27306, 0, 15000);
		run_random(150);
		program_regs(100, 300, 16'h8000 | 16'd500, 16'h8000 | 16'd1000, 16'hFFFF);
		run_random(150);
		program_regs(50, 100, 0, 20000, 100);
		run_random(150);
		program_regs(30, 300, 100, 8000, 8000);
		run_random(150);
		for (int p = 0; p < 4; p++) begin : rand_settings
			int cmin;
			cmin = $urandom_range(0, 20000);
			program_regs(16'($urandom_range(0, 1000)), 16'($urandom_range(0, 3000)),
				16'($urandom_range(0, 4000)), 16'(cmin),
				16'(cmin + int'($urandom_range(5, 12000))));
			if (p == 2)
				quiet <= 1'b1;
			run_random(160);
			quiet <= 1'b0;
		end

		settle();
		if (sb.pending() != 0)
			$display("%0d depth beats never came back", sb.pending());
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- files.f -----
src/tpdc_pkg.sv
src/tpdc_div.sv
src/tof_pixel_depth_colorize_top.sv
dv/tof_pixel_depth_colorize_top_test.sv
